// ===== rtl/rbd_pkg.sv =====
// Package: sizes, request codes and controller command type for the ring buffer deque.
package rbd_pkg;

  localparam int ENTRIES  = 256;
  localparam int PTR_W    = $clog2(ENTRIES);
  localparam int CNT_W    = PTR_W + 1;
  localparam int REQ_W    = 3;
  localparam int VAL_W    = 16;
  localparam int FILL_W   = 8;
  localparam int FILL_MAX = 255;

  localparam logic [REQ_W-1:0] REQ_PEEK       = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd1;
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd4;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [VAL_W-1:0] val_t;

  // Commands from the controller to the datapath, one phase per field.
  typedef struct packed {
    logic accept;    // take the request: write on push, move pointers
    logic rd_a;      // read popped slot and front slot
    logic rd_b;      // capture first reads, read back slot
    logic load_out;  // move the finished result into the output register
  } cmd_t;

endpackage

// ===== rtl/rbd_if.sv =====
// Interfaces: request channel and result channel of the ring buffer deque.
interface rbd_in_if;
  import rbd_pkg::*;
  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  logic [VAL_W-1:0] push_value;

  modport source (output valid, output req_type, output push_value, input ready);
  modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

interface rbd_out_if;
  import rbd_pkg::*;
  logic              valid;
  logic              ready;
  logic [VAL_W-1:0]  popped_value;
  logic [VAL_W-1:0]  front_value;
  logic [VAL_W-1:0]  back_value;
  logic              is_empty;
  logic              is_full;
  logic [FILL_W-1:0] fill_count;
  logic              request_refused;

  modport source (output valid, output popped_value, output front_value, output back_value,
                  output is_empty, output is_full, output fill_count,
                  output request_refused, input ready);
  modport sink   (input valid, input popped_value, input front_value, input back_value,
                  input is_empty, input is_full, input fill_count,
                  input request_refused, output ready);
endinterface

// ===== rtl/ring_buffer_deque_unit.sv =====
// Top level: ring buffer double-ended queue with request and result channels.
//
// Usage:
//   in_ch  carries one request: req_type (peek, push front, push back,
//          pop front, pop back; unused codes act as a peek) and push_value.
//   out_ch carries one result per request: popped value, front and back
//          values, empty and full flags, saturated fill count and a refused
//          flag for a push on a full queue or a pop on an empty one.
//   Both channels transfer on a rising edge with valid and ready high.
// Timing: one request at a time. The accept cycle writes a pushed value and
//   moves the pointers; the single slot memory then reads on its two read
//   ports in state RD_A (popped and front slots), then in state RD_B (the
//   back slot), and state WB loads the output register.
// Stall: the output register holds a finished result while out_ch.ready is
//   low; the next request is still taken and waits in state WB until
//   the register frees.
// Reset (rst_n low, synchronous): queue empty, front pointer 0, back pointer
//   at the top slot, no result pending. Slot contents are not cleared.
module ring_buffer_deque_unit (
  input logic      clk,
  input logic      rst_n,
  rbd_in_if.sink   in_ch,
  rbd_out_if.source out_ch
);
  import rbd_pkg::*;

  cmd_t cmd;

  rbd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  rbd_dpath u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .in_req_type         (in_ch.req_type),
    .in_push_value       (in_ch.push_value),
    .out_popped_value    (out_ch.popped_value),
    .out_front_value     (out_ch.front_value),
    .out_back_value      (out_ch.back_value),
    .out_is_empty        (out_ch.is_empty),
    .out_is_full         (out_ch.is_full),
    .out_fill_count      (out_ch.fill_count),
    .out_request_refused (out_ch.request_refused)
  );

endmodule

// ===== rtl/rbd_ctrl.sv =====
// Controller: sequences accept, slot reads and result load for one request at a time.
module rbd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output rbd_pkg::cmd_t cmd
);
  import rbd_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD_A = 2'd1;
  localparam logic [1:0] S_RD_B = 2'd2;
  localparam logic [1:0] S_WB   = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    cmd.accept   = in_valid && (state_r == S_IDLE);
    cmd.rd_a     = (state_r == S_RD_A);
    cmd.rd_b     = (state_r == S_RD_B);
    cmd.load_out = (state_r == S_WB) && out_free;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_RD_A;
      S_RD_A: state_nxt = S_RD_B;
      S_RD_B: state_nxt = S_WB;
      S_WB:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // A loaded result is presented in the next cycle.
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("loaded result not presented");

  // An accepted request always starts the read sequence.
  a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> (state_r == S_RD_A))
    else $error("accepted request did not start reads");

  // Never overwrite a result that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result register overwritten");

endmodule

// ===== rtl/rbd_dpath.sv =====
// Datapath: slot memory, front and back pointers, status and result registers.
module rbd_dpath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  rbd_pkg::cmd_t             cmd,
  input  logic [rbd_pkg::REQ_W-1:0] in_req_type,
  input  logic [rbd_pkg::VAL_W-1:0] in_push_value,
  output logic [rbd_pkg::VAL_W-1:0] out_popped_value,
  output logic [rbd_pkg::VAL_W-1:0] out_front_value,
  output logic [rbd_pkg::VAL_W-1:0] out_back_value,
  output logic                      out_is_empty,
  output logic                      out_is_full,
  output logic [rbd_pkg::FILL_W-1:0] out_fill_count,
  output logic                      out_request_refused
);
  import rbd_pkg::*;

  function automatic ptr_t ring_inc(input ptr_t p);
    return (p == PTR_W'(ENTRIES - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic ptr_t ring_dec(input ptr_t p);
    return (p == '0) ? PTR_W'(ENTRIES - 1) : p - 1'b1;
  endfunction

  val_t mem [ENTRIES];

  ptr_t fp_r, fp_nxt;
  ptr_t bp_r, bp_nxt;
  ptr_t pop_addr_r, pop_addr_nxt;
  logic is_pop_r, is_pop_nxt;
  logic refused_r, refused_nxt;
  logic wr_en;
  ptr_t wr_addr;
  val_t rdata0_r, rdata1_r;
  val_t popped_w_r, front_w_r;

  logic             empty, full;
  logic [CNT_W-1:0] diff, count;
  logic [FILL_W-1:0] fill_sat;

  val_t             popped_out_r, front_out_r, back_out_r;
  logic             empty_out_r, full_out_r, refused_out_r;
  logic [FILL_W-1:0] fill_out_r;

  assign empty = (fp_r == ring_inc(bp_r));
  assign full  = (fp_r == bp_r);

  // Count is (front - back - 1) mod ENTRIES; one conditional subtract wraps it.
  assign diff  = {1'b0, fp_r} + CNT_W'(ENTRIES) - {1'b0, bp_r} - CNT_W'(1);
  assign count = (diff >= CNT_W'(ENTRIES)) ? diff - CNT_W'(ENTRIES) : diff;
  assign fill_sat = (32'(count) > 32'(FILL_MAX)) ? FILL_W'(FILL_MAX) : FILL_W'(count);

  always_comb begin
    fp_nxt       = fp_r;
    bp_nxt       = bp_r;
    pop_addr_nxt = pop_addr_r;
    is_pop_nxt   = is_pop_r;
    refused_nxt  = refused_r;
    wr_en        = 1'b0;
    wr_addr      = fp_r;
    if (cmd.accept) begin
      is_pop_nxt  = 1'b0;
      refused_nxt = 1'b0;
      case (in_req_type)
        REQ_PUSH_FRONT: begin
          if (full) begin
            refused_nxt = 1'b1;
          end else begin
            wr_en   = 1'b1;
            wr_addr = fp_r;
            fp_nxt  = ring_inc(fp_r);
          end
        end
        REQ_PUSH_BACK: begin
          if (full) begin
            refused_nxt = 1'b1;
          end else begin
            wr_en   = 1'b1;
            wr_addr = bp_r;
            bp_nxt  = ring_dec(bp_r);
          end
        end
        REQ_POP_FRONT: begin
          if (empty) begin
            refused_nxt = 1'b1;
          end else begin
            fp_nxt       = ring_dec(fp_r);
            pop_addr_nxt = ring_dec(fp_r);
            is_pop_nxt   = 1'b1;
          end
        end
        REQ_POP_BACK: begin
          if (empty) begin
            refused_nxt = 1'b1;
          end else begin
            bp_nxt       = ring_inc(bp_r);
            pop_addr_nxt = ring_inc(bp_r);
            is_pop_nxt   = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fp_r <= '0;
      bp_r <= PTR_W'(ENTRIES - 1);
    end else begin
      fp_r <= fp_nxt;
      bp_r <= bp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pop_addr_r <= pop_addr_nxt;
    is_pop_r   <= is_pop_nxt;
    refused_r  <= refused_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_push_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_a) begin
      rdata0_r <= mem[pop_addr_r];
      rdata1_r <= mem[ring_dec(fp_r)];
    end else if (cmd.rd_b) begin
      rdata0_r <= mem[ring_inc(bp_r)];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_b) begin
      popped_w_r <= rdata0_r;
      front_w_r  <= rdata1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      popped_out_r  <= is_pop_r ? popped_w_r : '0;
      front_out_r   <= empty ? '0 : front_w_r;
      back_out_r    <= empty ? '0 : rdata0_r;
      empty_out_r   <= empty;
      full_out_r    <= full;
      fill_out_r    <= fill_sat;
      refused_out_r <= refused_r;
    end
  end

  assign out_popped_value    = popped_out_r;
  assign out_front_value     = front_out_r;
  assign out_back_value      = back_out_r;
  assign out_is_empty        = empty_out_r;
  assign out_is_full         = full_out_r;
  assign out_fill_count      = fill_out_r;
  assign out_request_refused = refused_out_r;

  // The pointer pair can never describe an empty and a full queue at once.
  a_not_both: assert property (@(posedge clk) disable iff (!rst_n)
    !(empty && full))
    else $error("queue both empty and full");

  // A refused request leaves both pointers where they were.
  a_refused_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && refused_nxt) |=> ($stable(fp_r) && $stable(bp_r)))
    else $error("refused request moved a pointer");

endmodule

// ===== dv/ring_buffer_deque_unit_test.sv =====
// Self-checking testbench for the ring buffer deque: directed and random request traffic.
module ring_buffer_deque_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rbd_pkg::*;

  localparam int ITEM_TARGET      = 800;
  localparam int MAX_GAP          = 8;
  localparam int CALM_SPAN        = 40;
  localparam int LONG_HOLD_AT     = 300;
  localparam int LONG_HOLD_CYCLES = 200;
  localparam int SETTLE_CYCLES    = 16;
  localparam int REPORT_LIMIT     = 10;

  // One request waiting to be offered, with the idle cycles that go before it.
  typedef struct {
    logic [REQ_W-1:0] code;
    val_t             value;
    int unsigned      gap;
    bit               drain_first;  // hold until every earlier result has come back
  } deque_request_t;

  // The deque as seen after one request: everything the result channel carries.
  typedef struct packed {
    val_t              popped_value;
    val_t              front_value;
    val_t              back_value;
    logic              is_empty;
    logic              is_full;
    logic [FILL_W-1:0] fill_count;
    logic              request_refused;
  } deque_view_t;

  logic clk = 1'b0;
  logic rst_n;

  rbd_in_if  in_ch ();
  rbd_out_if out_ch ();

  ring_buffer_deque_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  deque_request_t pending_requests[$];
  deque_view_t    expected_views[$];

  int  total_items;
  int  mismatch_count = 0;
  int  checked_count  = 0;  // advanced with a nonblocking write, so other blocks see it stable
  int  issued_count;
  bit  sender_calm;

  // Driver state.
  int unsigned    gap_left;
  bit             gap_armed;
  deque_request_t next_request;

  // Receiver state.
  int  delivered_count;
  int  stall_left;
  bit  receiver_calm;

  // Monitor scratch.
  deque_view_t seen_view;
  deque_view_t want_view;

  // ---------------------------------------------------------------------------
  // Deque mirror: slot copy plus the two wrapping pointers. front_idx names the
  // free slot just past the front value, back_idx the free slot just before the
  // back value; one slot always stays free.
  // ---------------------------------------------------------------------------
  val_t mirror_slots [ENTRIES];
  int   front_idx;
  int   back_idx;

  function automatic int wrap_up(int p);
    return (p + 1 >= ENTRIES) ? 0 : p + 1;
  endfunction

  function automatic int wrap_down(int p);
    return (p == 0) ? ENTRIES - 1 : p - 1;
  endfunction

  function automatic bit mirror_empty();
    return front_idx == wrap_up(back_idx);
  endfunction

  // Apply one request to the mirror and return the view the block must report.
  function automatic deque_view_t apply_request(logic [REQ_W-1:0] code, val_t value);
    deque_view_t view;
    int          held;
    view = '0;
    case (code)
      REQ_PUSH_FRONT: begin
        // Drop a push on a full queue and flag it.
        if (front_idx == back_idx) begin
          view.request_refused = 1'b1;
        end else begin
          mirror_slots[front_idx] = value;
          front_idx = wrap_up(front_idx);
        end
      end
      REQ_PUSH_BACK: begin
        if (front_idx == back_idx) begin
          view.request_refused = 1'b1;
        end else begin
          mirror_slots[back_idx] = value;
          back_idx = wrap_down(back_idx);
        end
      end
      REQ_POP_FRONT: begin
        // A pop on an empty queue returns zero and is flagged.
        if (mirror_empty()) begin
          view.request_refused = 1'b1;
        end else begin
          front_idx = wrap_down(front_idx);
          view.popped_value = mirror_slots[front_idx];
        end
      end
      REQ_POP_BACK: begin
        if (mirror_empty()) begin
          view.request_refused = 1'b1;
        end else begin
          back_idx = wrap_up(back_idx);
          view.popped_value = mirror_slots[back_idx];
        end
      end
      default: begin
        // Peek and the unused codes leave the queue as it is.
      end
    endcase
    if (!mirror_empty()) begin
      view.front_value = mirror_slots[wrap_down(front_idx)];
      view.back_value  = mirror_slots[wrap_up(back_idx)];
    end
    held = (front_idx - back_idx - 1 + 2 * ENTRIES) % ENTRIES;
    view.is_empty   = mirror_empty();
    view.is_full    = (front_idx == back_idx);
    view.fill_count = FILL_W'((held > FILL_MAX) ? FILL_MAX : held);
    return view;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // Append a request; every CALM_SPAN requests, redraw whether the sender idles.
  function automatic void queue_request(logic [REQ_W-1:0] code, val_t value, bit drain_first);
    deque_request_t item;
    if (pending_requests.size() % CALM_SPAN == 0) begin
      sender_calm = ($urandom_range(0, 3) == 0);
    end
    item.code        = code;
    item.value       = value;
    item.gap         = sender_calm ? 0 : $urandom_range(0, MAX_GAP);
    item.drain_first = drain_first;
    pending_requests.push_back(item);
  endfunction

  // Pick a request code; push_pct biases pushes against pops.
  function automatic logic [REQ_W-1:0] random_code(int push_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      return REQ_W'($urandom_range(REQ_POP_BACK + 1, (1 << REQ_W) - 1));
    end
    if (roll < 10) begin
      return REQ_PEEK;
    end
    if ($urandom_range(0, 99) < push_pct) begin
      return $urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
    end
    return $urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK;
  endfunction

  // Mostly random values, with the all-zeros and all-ones extremes mixed in.
  function automatic val_t random_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return val_t'($urandom);
    endcase
  endfunction

  function automatic void note_mismatch(string what, deque_view_t want, deque_view_t seen);
    if (mismatch_count < REPORT_LIMIT) begin
      $display("%0t: %s", $realtime, what);
      $display("  expected pop=%h front=%h back=%h empty=%b full=%b fill=%0d refused=%b",
               want.popped_value, want.front_value, want.back_value, want.is_empty,
               want.is_full, want.fill_count, want.request_refused);
      $display("  actual   pop=%h front=%h back=%h empty=%b full=%b fill=%0d refused=%b",
               seen.popped_value, seen.front_value, seen.back_value, seen.is_empty,
               seen.is_full, seen.fill_count, seen.request_refused);
    end
    mismatch_count++;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: predict each transfer, then offer the next pending request after its
  // gap. Requests marked drain_first hold until all results are back.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid  <= 1'b0;
      gap_armed    = 1'b0;
      gap_left     = 0;
      issued_count = 0;
      front_idx    = 0;
      back_idx     = ENTRIES - 1;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_views.push_back(apply_request(in_ch.req_type, in_ch.push_value));
        issued_count++;
      end
      // The channel is free when nothing is offered or the offer just transferred.
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_requests.size() == 0) begin
          in_ch.valid <= 1'b0;
        end else begin
          if (!gap_armed) begin
            gap_left  = pending_requests[0].gap;
            gap_armed = 1'b1;
          end
          if (gap_left > 0) begin
            gap_left--;
            in_ch.valid <= 1'b0;
          end else if (pending_requests[0].drain_first && issued_count != checked_count) begin
            in_ch.valid <= 1'b0;
          end else begin
            next_request = pending_requests.pop_front();
            gap_armed    = 1'b0;
            in_ch.valid      <= 1'b1;
            in_ch.req_type   <= next_request.code;
            in_ch.push_value <= next_request.value;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: after each transfer, drop ready for a random stall. Once, hold it
  // low for a long stretch so a finished result waits and the block stalls its input.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready    <= 1'b0;
      delivered_count = 0;
      stall_left      = 0;
      receiver_calm   = 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        delivered_count++;
        if (delivered_count % CALM_SPAN == 0) begin
          receiver_calm = ($urandom_range(0, 3) == 0);
        end
        if (delivered_count == LONG_HOLD_AT) begin
          stall_left = LONG_HOLD_CYCLES;
        end else begin
          stall_left = receiver_calm ? 0 : $urandom_range(0, MAX_GAP);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each result transfer with the oldest expected view.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      checked_count <= 0;
    end else if (out_ch.valid && out_ch.ready) begin
      seen_view = '{popped_value:    out_ch.popped_value,
                    front_value:     out_ch.front_value,
                    back_value:      out_ch.back_value,
                    is_empty:        out_ch.is_empty,
                    is_full:         out_ch.is_full,
                    fill_count:      out_ch.fill_count,
                    request_refused: out_ch.request_refused};
      if (expected_views.size() == 0) begin
        note_mismatch("result with no request outstanding", '0, seen_view);
      end else begin
        want_view = expected_views.pop_front();
        if (seen_view !== want_view) begin
          note_mismatch("result mismatch", want_view, seen_view);
        end
      end
      checked_count <= checked_count + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------------
  initial begin
    int push_pct;
    int moves;
    in_ch.valid      = 1'b0;
    in_ch.req_type   = REQ_PEEK;
    in_ch.push_value = '0;
    out_ch.ready     = 1'b0;
    rst_n            = 1'b0;

    // Directed: refused pops on empty, unused codes, value extremes at both
    // ends, pointer wrap at slot zero, and a return to empty.
    queue_request(REQ_PEEK, '0, 1'b0);
    queue_request(REQ_POP_FRONT, 16'h1234, 1'b0);
    queue_request(REQ_POP_BACK, '1, 1'b0);
    for (int c = REQ_POP_BACK + 1; c < (1 << REQ_W); c++) begin
      queue_request(REQ_W'(c), 16'hA5A5, 1'b0);
    end
    queue_request(REQ_PUSH_FRONT, 16'hFFFF, 1'b0);
    queue_request(REQ_PUSH_BACK, 16'h0000, 1'b0);
    queue_request(REQ_PEEK, 16'h5A5A, 1'b0);
    queue_request(REQ_PUSH_FRONT, 16'h0001, 1'b0);
    queue_request(REQ_PUSH_BACK, 16'h8000, 1'b0);
    queue_request(REQ_POP_BACK, '0, 1'b0);
    queue_request(REQ_POP_FRONT, '0, 1'b0);
    queue_request(REQ_POP_FRONT, '0, 1'b0);
    queue_request(REQ_POP_BACK, '0, 1'b0);
    queue_request(REQ_POP_BACK, '0, 1'b0);
    queue_request(REQ_PUSH_BACK, 16'hFFFF, 1'b0);
    queue_request(REQ_POP_FRONT, '0, 1'b0);
    queue_request(REQ_PUSH_FRONT, 16'h0000, 1'b0);
    queue_request(REQ_POP_BACK, '0, 1'b0);
    queue_request(REQ_PEEK, '1, 1'b0);

    // Fill past full from both ends so the last pushes are refused; let the
    // directed part drain first.
    moves = 0;
    queue_request(REQ_PEEK, random_value(), 1'b1);
    while (moves < ENTRIES + 4) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_request(REQ_PEEK, random_value(), 1'b0);
      end else begin
        queue_request($urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK,
                      random_value(), 1'b0);
        moves++;
      end
    end

    // Churn around the full mark.
    repeat (60) queue_request(random_code(55), random_value(), 1'b0);

    // Drain past empty from both ends so the last pops are refused.
    moves = 0;
    queue_request(REQ_PEEK, random_value(), 1'b1);
    while (moves < ENTRIES + 4) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_request(REQ_PEEK, random_value(), 1'b0);
      end else begin
        queue_request($urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK,
                      random_value(), 1'b0);
        moves++;
      end
    end

    // Mixed traffic in chunks that lean toward pushes, pops or neither; each
    // chunk starts from a drained pipeline.
    push_pct = 50;
    while (pending_requests.size() < ITEM_TARGET) begin
      if (pending_requests.size() % CALM_SPAN == 0) begin
        case ($urandom_range(0, 2))
          0:       push_pct = 85;
          1:       push_pct = 15;
          default: push_pct = 50;
        endcase
        queue_request(random_code(push_pct), random_value(), 1'b1);
      end else begin
        queue_request(random_code(push_pct), random_value(), 1'b0);
      end
    end
    total_items = pending_requests.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (checked_count < total_items) @(posedge clk);
    // Give a stray extra result time to show up.
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (expected_views.size() != 0) begin
      $display("%0d expected results never arrived", expected_views.size());
      mismatch_count += expected_views.size();
    end
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
